FILE: rtl/bmd_pkg.sv
`default_nettype none
package bmd_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 16;

  localparam int IN_W   = 16;
  localparam int ANG_W  = 16;
  localparam int CFG_W  = 16;
  localparam int RES_W  = 32;
  localparam int PH_W   = 32;
  localparam int CW     = 34;
  localparam int PROD_W = IN_W + RES_W;
  localparam int UC_W   = 31;
  localparam int C_W    = 32;
  localparam int D_W    = 48;
  localparam int LANES  = 4;

  localparam int TRIG_FRAC = 30;
  localparam int SPD_FRAC  = 8;
  localparam int LEN_FRAC  = 8;
  localparam int TINY_EXP  = 20;

  localparam int CORDIC_STEPS = 28;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int Q_W          = RES_W + 1;
  localparam int DIV_LAT      = Q_W + 1;

  localparam logic [CFG_W-1:0]     WHEELBASE_RST   = 16'd640;
  localparam logic signed [CW-1:0] CORDIC_GAIN_INV = 34'sd652032875;
  localparam logic [UC_W-1:0]      COS_MIN         = UC_W'(1) << TINY_EXP;
  localparam logic [RES_W-1:0]     RES_MAX         = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0]     RES_MIN         = {1'b1, {(RES_W-1){1'b0}}};

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic [RES_W-1:0] res_cos;
    logic [RES_W-1:0] res_sin;
    logic [RES_W-1:0] res_x;
    logic [RES_W-1:0] res_y;
    logic [RES_W-1:0] res_a;
    logic             sat;
    logic             tiny_cos;
    logic             neg_hr;
    logic             neg_ts;
    logic             neg_sp;
    logic             zero_hr;
    logic             zero_ts;
    logic             zero_sp;
  } side_t;

endpackage
`default_nettype wire

FILE: rtl/bmd_cordic.sv
`default_nettype none
module bmd_cordic
  import bmd_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int TAG_W      = 2 * IN_W
) (
  input  logic                   clk,
  input  logic [1:0][ANG_W-1:0]  angle,
  input  logic [TAG_W-1:0]       tag_in,
  output logic [1:0][RES_W-1:0]  sin_out,
  output logic [1:0][RES_W-1:0]  cos_out,
  output logic [TAG_W-1:0]       tag_out
);

  localparam logic [PH_W-1:0] PH_MASK = (PH_W'(1) << (PH_W - ANGLE_BITS)) - PH_W'(1);

  logic [TAG_W-1:0] tag_r [CORDIC_LAT];

  always_ff @(posedge clk) begin
    tag_r[0] <= tag_in;
    for (int k = 1; k < CORDIC_LAT; k++) begin
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign tag_out = tag_r[CORDIC_LAT-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [CW-1:0] x_r [CORDIC_STEPS+1];
    logic signed [CW-1:0] y_r [CORDIC_STEPS+1];
    logic signed [CW-1:0] z_r [CORDIC_STEPS];
    logic                 flip_r [CORDIC_STEPS+1];
    logic [RES_W-1:0]     cos_r;
    logic [RES_W-1:0]     sin_r;
    logic [PH_W-1:0]      ph;
    logic [PH_W-1:0]      ph_rot;
    logic                 fl;

    // fold into the right half plane
    always_comb begin
      ph     = {angle[l], {(PH_W-ANG_W){1'b0}}} & ~PH_MASK;
      fl     = ph[PH_W-1] ^ ph[PH_W-2];
      ph_rot = {ph[PH_W-1] ^ fl, ph[PH_W-2:0]};
    end

    always_ff @(posedge clk) begin
      x_r[0]    <= CORDIC_GAIN_INV;
      y_r[0]    <= '0;
      z_r[0]    <= CW'($signed(ph_rot));
      flip_r[0] <= fl;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_it
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic                 up;

      always_comb begin
        dx = y_r[k] >>> k;
        dy = x_r[k] >>> k;
        up = !z_r[k][CW-1];
      end

      always_ff @(posedge clk) begin
        x_r[k+1]    <= up ? x_r[k] - dx : x_r[k] + dx;
        y_r[k+1]    <= up ? y_r[k] + dy : y_r[k] - dy;
        flip_r[k+1] <= flip_r[k];
      end

      if (k < CORDIC_STEPS - 1) begin : g_z
        logic signed [CW-1:0] da;
        assign da = CW'(ATAN_TAB[k]);
        always_ff @(posedge clk) begin
          z_r[k+1] <= up ? z_r[k] - da : z_r[k] + da;
        end
      end
    end

    always_ff @(posedge clk) begin
      cos_r <= RES_W'(flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS]);
      sin_r <= RES_W'(flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS]);
    end

    assign cos_out[l] = cos_r;
    assign sin_out[l] = sin_r;
  end

endmodule
`default_nettype wire

FILE: rtl/bmd_div.sv
`default_nettype none
module bmd_div
  import bmd_pkg::*;
#(
  parameter int N_W   = 64,
  parameter int TAG_W = 1
) (
  input  logic                      clk,
  input  logic [LANES-1:0][N_W-1:0] num,
  input  logic [LANES-1:0][D_W-1:0] den,
  input  logic [TAG_W-1:0]          tag_in,
  output logic [LANES-1:0][Q_W-1:0] quo,
  output logic [LANES-1:0]          ovf,
  output logic [TAG_W-1:0]          tag_out
);

  logic [TAG_W-1:0] tag_r [Q_W+1];

  always_ff @(posedge clk) begin
    tag_r[0] <= tag_in;
    for (int k = 1; k <= Q_W; k++) begin
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign tag_out = tag_r[Q_W];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [D_W-1:0] rem_r [Q_W];
    logic [D_W-1:0] den_r [Q_W];
    logic [Q_W-1:0] lo_r  [Q_W];
    logic [Q_W-1:0] q_r   [Q_W+1];
    logic           ovf_r [Q_W+1];
    logic [D_W-1:0] hi;

    assign hi = D_W'(num[l][N_W-1:Q_W]);

    // quotient of more than Q_W bits is flagged up front
    always_ff @(posedge clk) begin
      rem_r[0] <= hi;
      den_r[0] <= den[l];
      lo_r[0]  <= num[l][Q_W-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= hi >= den[l];
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_bit
      logic [D_W:0] t;
      logic         hit;

      always_comb begin
        t   = {rem_r[k], lo_r[k][Q_W-1]};
        hit = t >= {1'b0, den_r[k]};
      end

      always_ff @(posedge clk) begin
        q_r[k+1]   <= {q_r[k][Q_W-2:0], hit};
        ovf_r[k+1] <= ovf_r[k];
      end

      if (k < Q_W - 1) begin : g_rem
        always_ff @(posedge clk) begin
          rem_r[k+1] <= hit ? D_W'(t - {1'b0, den_r[k]}) : D_W'(t);
          den_r[k+1] <= den_r[k];
          lo_r[k+1]  <= lo_r[k] << 1;
        end
      end
    end

    assign quo[l] = q_r[Q_W];
    assign ovf[l] = ovf_r[Q_W];
  end

endmodule
`default_nettype wire

FILE: rtl/bicycle_model_derivatives.sv
// Kinematic bicycle model: derivative and Jacobian/Hessian terms per sample.
// Input: pulse start with the four in_ fields; a word is taken on every clock
// edge where start is high (busy stays low, one word per cycle sustained).
// Output: out_valid is high for one cycle with all out_ fields and the
// saturated flag; the receiver must take it then, it cannot stall the block.
// From start to out_valid a word passes a 30-stage pipelined CORDIC
// for both angles, four multiply stages for the denominators, and four
// pipelined restoring dividers of 33 quotient bits, one bit per stage.
// Words leave in the order they entered, one per cycle at full rate.
// Config: cfg_wr_en writes cfg_wr_data into the wheelbase register (Q8.8);
// change it only while no word is in flight. A wheelbase of 0 acts as 1 LSB.
// Reset (rst_n low, synchronous) empties the pipeline and sets the wheelbase
// to 640 (2.5 m). Words in flight at reset are dropped.
`default_nettype none
module bicycle_model_derivatives
  import bmd_pkg::*;
#(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  in_heading_angle,
  input  logic signed [IN_W-1:0]  in_speed,
  input  logic signed [IN_W-1:0]  in_acceleration,
  input  logic signed [IN_W-1:0]  in_steer_angle,
  input  logic                    cfg_wr_en,
  input  logic [CFG_W-1:0]        cfg_wr_data,
  output logic                    out_valid,
  output logic signed [RES_W-1:0] out_heading_cos,
  output logic signed [RES_W-1:0] out_heading_sin,
  output logic signed [RES_W-1:0] out_x_rate,
  output logic signed [RES_W-1:0] out_y_rate,
  output logic signed [RES_W-1:0] out_heading_rate,
  output logic signed [RES_W-1:0] out_speed_rate,
  output logic signed [RES_W-1:0] out_turn_per_speed,
  output logic signed [RES_W-1:0] out_turn_per_steer,
  output logic signed [RES_W-1:0] out_steer_curvature_term,
  output logic                    out_saturated
);

  localparam int SH_T   = TRIG_FRAC - OUT_FRAC_BITS;
  localparam int SH_V   = TRIG_FRAC + SPD_FRAC - OUT_FRAC_BITS;
  localparam int SH_A   = OUT_FRAC_BITS - SPD_FRAC;
  localparam int N_W    = 2 * IN_W + 2 * UC_W - TRIG_FRAC + 1 + OUT_FRAC_BITS + 1;
  localparam int TOTAL  = CORDIC_LAT + 4 + DIV_LAT + 1;
  localparam int SIDE_W = $bits(side_t);
  localparam int UVUS_W = IN_W + UC_W;
  localparam int C2UC_W = C_W + UC_W;

  localparam logic signed [RES_W:0]  HALF_T = (RES_W+1)'(1 <<< (SH_T - 1));
  localparam logic signed [PROD_W:0] HALF_V = (PROD_W+1)'(1 <<< (SH_V - 1));

  function automatic logic [RES_W:0] sat_res(input logic signed [PROD_W:0] v);
    logic fits;
    fits = (v[PROD_W:RES_W-1] == '0) || (v[PROD_W:RES_W-1] == '1);
    if (fits) begin
      return {1'b0, v[RES_W-1:0]};
    end else if (v[PROD_W]) begin
      return {1'b1, RES_MIN};
    end else begin
      return {1'b1, RES_MAX};
    end
  endfunction

  // control
  logic [CFG_W-1:0] wheelbase_r, wheelbase_nxt;
  logic [TOTAL-1:0] vld_r, vld_nxt;
  logic [CFG_W-1:0] len;

  assign busy = 1'b0;

  always_comb begin
    wheelbase_nxt = cfg_wr_en ? cfg_wr_data : wheelbase_r;
    vld_nxt       = {vld_r[TOTAL-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= WHEELBASE_RST;
      vld_r       <= '0;
    end else begin
      wheelbase_r <= wheelbase_nxt;
      vld_r       <= vld_nxt;
    end
  end

  assign len = (wheelbase_r == '0) ? CFG_W'(1) : wheelbase_r;

  // sine / cosine of both angles
  logic [1:0][RES_W-1:0] trig_sin, trig_cos;
  logic [2*IN_W-1:0]     trig_tag;

  bmd_cordic #(
    .ANGLE_BITS (ANGLE_BITS),
    .TAG_W      (2 * IN_W)
  ) u_cordic (
    .clk     (clk),
    .angle   ({in_steer_angle, in_heading_angle}),
    .tag_in  ({in_speed, in_acceleration}),
    .sin_out (trig_sin),
    .cos_out (trig_cos),
    .tag_out (trig_tag)
  );

  logic signed [RES_W-1:0] ct, st, cd, sd;
  logic signed [IN_W-1:0]  v_in, a_in;
  logic signed [RES_W:0]   ct_rnd, st_rnd;

  assign ct = trig_cos[0];
  assign st = trig_sin[0];
  assign cd = trig_cos[1];
  assign sd = trig_sin[1];
  assign v_in = trig_tag[2*IN_W-1:IN_W];
  assign a_in = trig_tag[IN_W-1:0];
  assign ct_rnd = ((RES_W+1)'(ct) + HALF_T) >>> SH_T;
  assign st_rnd = ((RES_W+1)'(st) + HALF_T) >>> SH_T;

  // stage 1: heading terms, speed products, magnitudes
  logic [RES_W-1:0]         s1_res_cos_r, s1_res_sin_r, s1_res_a_r;
  logic signed [PROD_W-1:0] s1_vct_r, s1_vst_r;
  logic [UC_W-1:0]          s1_uc_r, s1_us_r;
  logic [IN_W-1:0]          s1_uv_r;
  logic                     s1_nv_r, s1_ns_r, s1_nc_r, s1_zv_r, s1_zs_r;

  always_ff @(posedge clk) begin
    s1_res_cos_r <= RES_W'(ct_rnd);
    s1_res_sin_r <= RES_W'(st_rnd);
    s1_res_a_r   <= RES_W'(a_in) <<< SH_A;
    s1_vct_r     <= PROD_W'(v_in) * PROD_W'(ct);
    s1_vst_r     <= PROD_W'(v_in) * PROD_W'(st);
    s1_uc_r      <= cd[RES_W-1] ? UC_W'(-cd) : UC_W'(cd);
    s1_us_r      <= sd[RES_W-1] ? UC_W'(-sd) : UC_W'(sd);
    s1_uv_r      <= v_in[IN_W-1] ? IN_W'(-v_in) : IN_W'(v_in);
    s1_nv_r      <= v_in[IN_W-1];
    s1_ns_r      <= sd[RES_W-1];
    s1_nc_r      <= cd[RES_W-1];
    s1_zv_r      <= (v_in == '0);
    s1_zs_r      <= (sd == '0);
  end

  // stage 2: rounding of rates, cos squared, numerator and denominator products
  logic signed [PROD_W:0] vct_rnd, vst_rnd;
  logic [RES_W:0]         x_sat, y_sat;
  side_t                  side_p2;

  always_comb begin
    vct_rnd = ((PROD_W+1)'(s1_vct_r) + HALF_V) >>> SH_V;
    vst_rnd = ((PROD_W+1)'(s1_vst_r) + HALF_V) >>> SH_V;
    x_sat   = sat_res(vct_rnd);
    y_sat   = sat_res(vst_rnd);
    side_p2.res_cos  = s1_res_cos_r;
    side_p2.res_sin  = s1_res_sin_r;
    side_p2.res_x    = x_sat[RES_W-1:0];
    side_p2.res_y    = y_sat[RES_W-1:0];
    side_p2.res_a    = s1_res_a_r;
    side_p2.sat      = x_sat[RES_W] | y_sat[RES_W];
    side_p2.tiny_cos = s1_uc_r < COS_MIN;
    side_p2.neg_hr   = s1_nv_r ^ s1_ns_r ^ s1_nc_r;
    side_p2.neg_ts   = s1_ns_r ^ s1_nc_r;
    side_p2.neg_sp   = s1_nv_r;
    side_p2.zero_hr  = s1_zv_r | s1_zs_r;
    side_p2.zero_ts  = s1_zs_r;
    side_p2.zero_sp  = s1_zv_r;
  end

  side_t               s2_side_r;
  logic [2*UC_W-1:0]   s2_ucuc_r;
  logic [UVUS_W-1:0]   s2_uvus_r;
  logic [D_W-1:0]      s2_ucl_r;
  logic [UC_W-1:0]     s2_uc_r, s2_us_r;
  logic [IN_W-1:0]     s2_uv_r;

  always_ff @(posedge clk) begin
    s2_side_r <= side_p2;
    s2_ucuc_r <= (2*UC_W)'(s1_uc_r) * (2*UC_W)'(s1_uc_r);
    s2_uvus_r <= UVUS_W'(s1_uv_r) * UVUS_W'(s1_us_r);
    s2_ucl_r  <= D_W'(s1_uc_r) * D_W'(len);
    s2_uc_r   <= s1_uc_r;
    s2_us_r   <= s1_us_r;
    s2_uv_r   <= s1_uv_r;
  end

  // stage 3: cos cubed product, c2 * L
  logic [C_W-1:0] c2;
  assign c2 = C_W'(s2_ucuc_r >> TRIG_FRAC);

  side_t             s3_side_r;
  logic [C2UC_W-1:0] s3_c2uc_r;
  logic [D_W-1:0]    s3_c2l_r, s3_ucl_r;
  logic [UVUS_W-1:0] s3_uvus_r;
  logic [UC_W-1:0]   s3_us_r;
  logic [IN_W-1:0]   s3_uv_r;

  always_ff @(posedge clk) begin
    s3_side_r <= s2_side_r;
    s3_c2uc_r <= C2UC_W'(c2) * C2UC_W'(s2_uc_r);
    s3_c2l_r  <= D_W'(c2) * D_W'(len);
    s3_ucl_r  <= s2_ucl_r;
    s3_uvus_r <= s2_uvus_r;
    s3_us_r   <= s2_us_r;
    s3_uv_r   <= s2_uv_r;
  end

  // stage 4: c3 * L and aligned numerators
  logic [C_W-1:0] c3;
  assign c3 = C_W'(s3_c2uc_r >> TRIG_FRAC);

  side_t                     s4_side_r;
  logic [LANES-1:0][N_W-1:0] s4_num_r;
  logic [LANES-1:0][D_W-1:0] s4_den_r;

  always_ff @(posedge clk) begin
    s4_side_r   <= s3_side_r;
    s4_num_r[0] <= N_W'(s3_uvus_r) << OUT_FRAC_BITS;
    s4_num_r[1] <= N_W'(s3_us_r) << (LEN_FRAC + OUT_FRAC_BITS);
    s4_num_r[2] <= N_W'(s3_uv_r) << (TRIG_FRAC + OUT_FRAC_BITS);
    s4_num_r[3] <= N_W'(s3_uvus_r) << (OUT_FRAC_BITS + 1);
    s4_den_r[0] <= s3_ucl_r;
    s4_den_r[1] <= s3_ucl_r;
    s4_den_r[2] <= s3_c2l_r;
    s4_den_r[3] <= D_W'(c3) * D_W'(len);
  end

  // dividers: heading_rate, turn_per_speed, turn_per_steer, curvature term
  logic [LANES-1:0][Q_W-1:0] div_quo;
  logic [LANES-1:0]          div_ovf;
  logic [SIDE_W-1:0]         div_tag;

  bmd_div #(
    .N_W   (N_W),
    .TAG_W (SIDE_W)
  ) u_div (
    .clk     (clk),
    .num     (s4_num_r),
    .den     (s4_den_r),
    .tag_in  (s4_side_r),
    .quo     (div_quo),
    .ovf     (div_ovf),
    .tag_out (div_tag)
  );

  // output stage: sign, clamp, near-right-angle steering
  side_t                       side_o;
  logic [LANES-1:0]            lane_neg, lane_zero;
  logic [LANES-1:0][RES_W-1:0] lane_val;
  logic                        clamp_any;

  always_comb begin
    logic big;
    side_o    = side_t'(div_tag);
    lane_neg  = {side_o.neg_hr, side_o.neg_sp, side_o.neg_ts, side_o.neg_hr};
    lane_zero = {side_o.zero_hr, side_o.zero_sp, side_o.zero_ts, side_o.zero_hr};
    clamp_any = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      big = div_ovf[l] | div_quo[l][Q_W-1];
      if (side_o.tiny_cos) begin
        if (lane_zero[l]) begin
          lane_val[l] = '0;
        end else begin
          lane_val[l] = lane_neg[l] ? RES_MIN : RES_MAX;
        end
      end else if (lane_neg[l]) begin
        if (big | (div_quo[l][RES_W-1] & (|div_quo[l][RES_W-2:0]))) begin
          lane_val[l] = RES_MIN;
          clamp_any   = 1'b1;
        end else begin
          lane_val[l] = -div_quo[l][RES_W-1:0];
        end
      end else begin
        if (big | div_quo[l][RES_W-1]) begin
          lane_val[l] = RES_MAX;
          clamp_any   = 1'b1;
        end else begin
          lane_val[l] = div_quo[l][RES_W-1:0];
        end
      end
    end
  end

  logic [RES_W-1:0] cos_r, sin_r, x_r, y_r, hr_r, sr_r, tps_r, tpst_r, curv_r;
  logic             sat_r;

  always_ff @(posedge clk) begin
    cos_r  <= side_o.res_cos;
    sin_r  <= side_o.res_sin;
    x_r    <= side_o.res_x;
    y_r    <= side_o.res_y;
    sr_r   <= side_o.res_a;
    hr_r   <= lane_val[0];
    tps_r  <= lane_val[1];
    tpst_r <= lane_val[2];
    curv_r <= lane_val[3];
    sat_r  <= side_o.sat | side_o.tiny_cos | clamp_any;
  end

  assign out_valid                = vld_r[TOTAL-1];
  assign out_heading_cos          = cos_r;
  assign out_heading_sin          = sin_r;
  assign out_x_rate               = x_r;
  assign out_y_rate               = y_r;
  assign out_heading_rate         = hr_r;
  assign out_speed_rate           = sr_r;
  assign out_turn_per_speed       = tps_r;
  assign out_turn_per_steer       = tpst_r;
  assign out_steer_curvature_term = curv_r;
  assign out_saturated            = sat_r;

endmodule
`default_nettype wire
